// ===== hw/rtl/assert_macros.svh =====
// assertion macros for the rtl files that check themselves
// expects signals named clk and rst in the scope of use
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, off while in reset
`define ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, off while in reset
`define ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== hw/rtl/ppsc_pkg.sv =====
// shared types and constants of the ph probe smoothing and calibration core
// no dependencies
package ppsc_pkg;

  localparam int SAMPLE_W    = 10;   // width of the sample port
  localparam int LEVEL_W     = 14;   // calibration level, unsigned q10.4
  localparam int SPAN_W      = 18;   // level scaled to q10.8
  localparam int PH_W        = 16;
  localparam int MEAN_FRAC   = 8;    // fraction bits of the first mean

  localparam int APB_ADDR_W  = 3;
  localparam int APB_DATA_W  = 32;

  localparam logic REG_PH7   = 1'b0;
  localparam logic REG_PH4   = 1'b1;

  localparam logic [LEVEL_W-1:0] PH7_RESET = 14'd8192;
  localparam logic [LEVEL_W-1:0] PH4_RESET = 14'd4704;

  localparam logic [PH_W-1:0] PH_SEVEN = 16'h0700;
  localparam logic [PH_W-1:0] PH_MAX   = 16'h7FFF;
  localparam logic [PH_W-1:0] PH_MIN   = 16'h8000;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = 1;
  localparam int QCNT_W      = 2;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

// ===== hw/rtl/ph_probe_smoothing_and_calibration_core.sv =====
// top level: configuration port, sample queue, averaging and calibration back end
// depends on ppsc_pkg, ppsc_front, ppsc_divider, ppsc_back and assert_macros.svh

// Each 10-bit sample goes through a moving average over RAW_WINDOW samples and a
// second one over AVG_WINDOW means, both averaging over what they hold while
// filling, and yields one result: pH in signed Q8.8 from the two calibration
// levels, saturated, with calibration_bad set and pH 7.0 when the levels match.
// Most of the work on a sample is done in the single shared one-bit-per-cycle
// divider, which is used for the two means and the calibration quotient in
// turn. A two-item queue in front takes samples while the back end works, and
// a result waiting at the output does not stop the next sample from being
// worked on up to the output state, where it waits for the result register.
// No clearing pass after reset. Calibration levels are written over the APB
// port at 0x0 (pH 7) and 0x4 (pH 4) and should only change while no sample
// is in flight.
`include "assert_macros.svh"

module ph_probe_smoothing_and_calibration_core #(
  parameter int RAW_WINDOW = 30,
  parameter int AVG_WINDOW = 15,
  parameter int ADC_BITS   = 10
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [ppsc_pkg::APB_ADDR_W-1:0]   paddr,
  input  logic [ppsc_pkg::APB_DATA_W-1:0]   pwdata,
  output logic [ppsc_pkg::APB_DATA_W-1:0]   prdata,
  output logic                              pready,
  input  logic [ppsc_pkg::SAMPLE_W-1:0]     adc_sample,
  input  logic                              sample_valid,
  output logic                              sample_ready,
  output logic signed [ppsc_pkg::PH_W-1:0]  ph_value,
  output logic                              calibration_bad,
  output logic                              result_valid,
  input  logic                              result_ready
);

  localparam int MEAN_W = ADC_BITS + ppsc_pkg::MEAN_FRAC;
  localparam int CMP_W  = (MEAN_W > ppsc_pkg::SPAN_W) ? MEAN_W : ppsc_pkg::SPAN_W;
  localparam int DIV_W  = CMP_W + 12;
  localparam int CNT_W  = $clog2(DIV_W + 1);

  logic [ppsc_pkg::LEVEL_W-1:0] ph7_level;
  logic [ppsc_pkg::LEVEL_W-1:0] ph4_level;
  logic                         cfg_wr;

  logic                         q_valid;
  logic [ADC_BITS-1:0]          q_data;
  logic                         q_pop;

  logic                         div_start;
  logic [DIV_W-1:0]             div_num;
  logic [ppsc_pkg::SPAN_W-1:0]  div_den;
  logic [CNT_W-1:0]             div_iters;
  ppsc_pkg::div_stat_t          div_stat;
  logic [DIV_W-1:0]             div_quo;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      ph7_level <= ppsc_pkg::PH7_RESET;
      ph4_level <= ppsc_pkg::PH4_RESET;
    end else if (cfg_wr) begin
      unique case (paddr[2])
        ppsc_pkg::REG_PH7: ph7_level <= pwdata[ppsc_pkg::LEVEL_W-1:0];
        ppsc_pkg::REG_PH4: ph4_level <= pwdata[ppsc_pkg::LEVEL_W-1:0];
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      ppsc_pkg::REG_PH7: prdata = ppsc_pkg::APB_DATA_W'(ph7_level);
      ppsc_pkg::REG_PH4: prdata = ppsc_pkg::APB_DATA_W'(ph4_level);
    endcase
  end

  ppsc_front #(
    .ADC_BITS (ADC_BITS)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .adc_sample   (adc_sample),
    .sample_valid (sample_valid),
    .sample_ready (sample_ready),
    .q_valid      (q_valid),
    .q_data       (q_data),
    .q_pop        (q_pop)
  );

  ppsc_divider #(
    .DIV_W (DIV_W),
    .DEN_W (ppsc_pkg::SPAN_W)
  ) u_divider (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .iters (div_iters),
    .stat  (div_stat),
    .quo   (div_quo)
  );

  ppsc_back #(
    .RAW_WINDOW (RAW_WINDOW),
    .AVG_WINDOW (AVG_WINDOW),
    .ADC_BITS   (ADC_BITS),
    .DIV_W      (DIV_W)
  ) u_back (
    .clk             (clk),
    .rst             (rst),
    .q_valid         (q_valid),
    .q_data          (q_data),
    .q_pop           (q_pop),
    .ph7_level       (ph7_level),
    .ph4_level       (ph4_level),
    .div_start       (div_start),
    .div_num         (div_num),
    .div_den         (div_den),
    .div_iters       (div_iters),
    .div_stat        (div_stat),
    .div_quo         (div_quo),
    .ph_value        (ph_value),
    .calibration_bad (calibration_bad),
    .result_valid    (result_valid),
    .result_ready    (result_ready)
  );

  // back end never takes from an empty queue
  `ASSERT_IMPL(a_pop_nonempty, q_pop, q_valid, "item taken from empty queue")
  // divider is never restarted in the middle of a division
  `ASSERT_IMPL(a_start_idle, div_start, !div_stat.busy, "divider restarted while busy")
  // a start always leaves the divider working in the next cycle
  `ASSERT_NEXT(a_start_busy, div_start, div_stat.busy, "divider did not start")
  // equal levels always give pH seven
  `ASSERT_IMPL(a_bad_seven, result_valid && calibration_bad, ph_value == ppsc_pkg::PH_SEVEN, "bad calibration without pH seven")

endmodule

// ===== hw/rtl/ppsc_front.sv =====
// front end: takes samples, keeps the converter bits in use, queues them
// depends on ppsc_pkg
module ppsc_front #(
  parameter int ADC_BITS = 10
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic [ppsc_pkg::SAMPLE_W-1:0] adc_sample,
  input  logic                          sample_valid,
  output logic                          sample_ready,
  output logic                          q_valid,
  output logic [ADC_BITS-1:0]           q_data,
  input  logic                          q_pop
);

  logic [ADC_BITS-1:0]             entries [ppsc_pkg::QUEUE_DEPTH];
  logic [ppsc_pkg::QPTR_W-1:0]     wr_ptr;
  logic [ppsc_pkg::QPTR_W-1:0]     rd_ptr;
  logic [ppsc_pkg::QCNT_W-1:0]     count;
  logic [ADC_BITS-1:0]             masked;
  logic                            push;

  // keep the low converter bits, zero above them
  assign masked       = ADC_BITS'(adc_sample);
  assign sample_ready = (count != ppsc_pkg::QCNT_W'(ppsc_pkg::QUEUE_DEPTH));
  assign push         = sample_valid && sample_ready;
  assign q_valid      = (count != '0);
  assign q_data       = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= masked;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (q_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !q_pop) begin
        count <= count + 1'b1;
      end else if (q_pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ===== hw/rtl/ppsc_divider.sv =====
// shared restoring divider, one quotient bit per cycle
// numerator comes left aligned, iters gives the number of steps; depends on ppsc_pkg
module ppsc_divider #(
  parameter int DIV_W = 30,
  parameter int DEN_W = 18
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [DIV_W-1:0]           num,
  input  logic [DEN_W-1:0]           den,
  input  logic [$clog2(DIV_W+1)-1:0] iters,
  output ppsc_pkg::div_stat_t        stat,
  output logic [DIV_W-1:0]           quo
);

  localparam int CNT_W = $clog2(DIV_W+1);

  logic [DEN_W-1:0] rem;
  logic [DEN_W-1:0] den_r;
  logic [CNT_W-1:0] cnt;
  logic [DEN_W:0]   trial;
  logic [DEN_W:0]   trial_sub;
  logic             fits;

  assign trial     = {rem, quo[DIV_W-1]};
  assign trial_sub = trial - {1'b0, den_r};
  assign fits      = (trial >= {1'b0, den_r});

  always_ff @(posedge clk) begin
    if (rst) begin
      stat.busy <= 1'b0;
      stat.done <= 1'b0;
    end else begin
      stat.done <= 1'b0;
      if (start) begin
        quo       <= num;
        rem       <= '0;
        den_r     <= den;
        cnt       <= iters;
        stat.busy <= 1'b1;
      end else if (stat.busy) begin
        rem <= fits ? trial_sub[DEN_W-1:0] : trial[DEN_W-1:0];
        quo <= {quo[DIV_W-2:0], fits};
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          stat.busy <= 1'b0;
          stat.done <= 1'b1;
        end
      end
    end
  end

endmodule

// ===== hw/rtl/ppsc_back.sv =====
// back end: both moving averages, two-point calibration and the result register
// depends on ppsc_pkg and drives the shared ppsc_divider
module ppsc_back #(
  parameter int RAW_WINDOW = 30,
  parameter int AVG_WINDOW = 15,
  parameter int ADC_BITS   = 10,
  parameter int DIV_W      = 30
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              q_valid,
  input  logic [ADC_BITS-1:0]               q_data,
  output logic                              q_pop,
  input  logic [ppsc_pkg::LEVEL_W-1:0]      ph7_level,
  input  logic [ppsc_pkg::LEVEL_W-1:0]      ph4_level,
  output logic                              div_start,
  output logic [DIV_W-1:0]                  div_num,
  output logic [ppsc_pkg::SPAN_W-1:0]       div_den,
  output logic [$clog2(DIV_W+1)-1:0]        div_iters,
  input  ppsc_pkg::div_stat_t               div_stat,
  input  logic [DIV_W-1:0]                  div_quo,
  output logic signed [ppsc_pkg::PH_W-1:0]  ph_value,
  output logic                              calibration_bad,
  output logic                              result_valid,
  input  logic                              result_ready
);

  localparam int SPAN_W     = ppsc_pkg::SPAN_W;
  localparam int PH_W       = ppsc_pkg::PH_W;
  localparam int MEAN_W     = ADC_BITS + ppsc_pkg::MEAN_FRAC;
  localparam int RAW_SUM_W  = $clog2(RAW_WINDOW * ((1 << ADC_BITS) - 1) + 1);
  localparam int AVG_SUM_W  = $clog2(AVG_WINDOW * ((1 << MEAN_W) - 1) + 1);
  localparam int RAW_FILL_W = $clog2(RAW_WINDOW + 1);
  localparam int AVG_FILL_W = $clog2(AVG_WINDOW + 1);
  localparam int RAW_SLOT_W = (RAW_WINDOW > 1) ? $clog2(RAW_WINDOW) : 1;
  localparam int AVG_SLOT_W = (AVG_WINDOW > 1) ? $clog2(AVG_WINDOW) : 1;
  localparam int CMP_W      = (MEAN_W > SPAN_W) ? MEAN_W : SPAN_W;
  localparam int NUM_MAG_W  = CMP_W + 12;
  localparam int CNT_W      = $clog2(DIV_W + 1);
  localparam int N1         = RAW_SUM_W + ppsc_pkg::MEAN_FRAC;
  localparam int N2         = AVG_SUM_W;
  localparam int N3         = NUM_MAG_W;

  typedef enum logic [9:0] {
    S_IDLE    = 10'b0000000001,
    S_RAW_UPD = 10'b0000000010,
    S_DIV1    = 10'b0000000100,
    S_AVG_UPD = 10'b0000001000,
    S_DIV2    = 10'b0000010000,
    S_CAL     = 10'b0000100000,
    S_NUM     = 10'b0001000000,
    S_START3  = 10'b0010000000,
    S_DIV3    = 10'b0100000000,
    S_OUT     = 10'b1000000000
  } state_t;

  state_t state;

  logic [ADC_BITS-1:0]   raw_ring [RAW_WINDOW];
  logic [MEAN_W-1:0]     avg_ring [AVG_WINDOW];
  logic [ADC_BITS-1:0]   raw_rdata;
  logic [MEAN_W-1:0]     avg_rdata;

  logic [RAW_SUM_W-1:0]  raw_sum;
  logic [RAW_FILL_W-1:0] raw_fill;
  logic [RAW_SLOT_W-1:0] raw_slot;
  logic [AVG_SUM_W-1:0]  avg_sum;
  logic [AVG_FILL_W-1:0] avg_fill;
  logic [AVG_SLOT_W-1:0] avg_slot;

  logic [ADC_BITS-1:0]   sample;
  logic [MEAN_W-1:0]     mean;
  logic [MEAN_W-1:0]     avg2;
  logic signed [SPAN_W:0]    span_r;
  logic signed [CMP_W:0]     diff_r;
  logic signed [NUM_MAG_W:0] num_r;
  logic                  bad_r;
  logic                  neg_r;

  logic                  raw_full;
  logic                  avg_full;
  logic [RAW_SUM_W-1:0]  raw_sum_next;
  logic [RAW_FILL_W-1:0] raw_fill_next;
  logic [RAW_SLOT_W-1:0] raw_slot_next;
  logic [AVG_SUM_W-1:0]  avg_sum_next;
  logic [AVG_FILL_W-1:0] avg_fill_next;
  logic [AVG_SLOT_W-1:0] avg_slot_next;
  logic signed [NUM_MAG_W:0] span_x;
  logic signed [NUM_MAG_W:0] diff_x;
  logic signed [NUM_MAG_W:0] num_neg;
  logic signed [SPAN_W:0]    span_neg;
  logic [PH_W-1:0]       ph_sat;

  assign raw_full      = (raw_fill == RAW_FILL_W'(RAW_WINDOW));
  assign avg_full      = (avg_fill == AVG_FILL_W'(AVG_WINDOW));
  assign raw_sum_next  = raw_sum + RAW_SUM_W'(sample)
                         - (raw_full ? RAW_SUM_W'(raw_rdata) : '0);
  assign avg_sum_next  = avg_sum + AVG_SUM_W'(mean)
                         - (avg_full ? AVG_SUM_W'(avg_rdata) : '0);
  assign raw_fill_next = raw_full ? raw_fill : raw_fill + 1'b1;
  assign avg_fill_next = avg_full ? avg_fill : avg_fill + 1'b1;
  assign raw_slot_next = (raw_slot == RAW_SLOT_W'(RAW_WINDOW - 1)) ? '0 : raw_slot + 1'b1;
  assign avg_slot_next = (avg_slot == AVG_SLOT_W'(AVG_WINDOW - 1)) ? '0 : avg_slot + 1'b1;

  // 1792 = 2048 - 256 and 768 = 512 + 256
  assign span_x   = (NUM_MAG_W+1)'(span_r);
  assign diff_x   = (NUM_MAG_W+1)'(diff_r);
  assign num_neg  = -num_r;
  assign span_neg = -span_r;

  assign q_pop = (state == S_IDLE) && q_valid;

  // divider requests: mean of raw window, mean of averages, calibration quotient
  always_comb begin
    div_start = 1'b0;
    div_num   = '0;
    div_den   = '0;
    div_iters = '0;
    if (state == S_RAW_UPD) begin
      div_start = 1'b1;
      div_num   = DIV_W'({raw_sum_next, {ppsc_pkg::MEAN_FRAC{1'b0}}}) << (DIV_W - N1);
      div_den   = SPAN_W'(raw_fill_next);
      div_iters = CNT_W'(N1);
    end else if (state == S_AVG_UPD) begin
      div_start = 1'b1;
      div_num   = DIV_W'(avg_sum_next) << (DIV_W - N2);
      div_den   = SPAN_W'(avg_fill_next);
      div_iters = CNT_W'(N2);
    end else if (state == S_START3) begin
      div_start = 1'b1;
      div_num   = DIV_W'(num_r[NUM_MAG_W] ? num_neg[NUM_MAG_W-1:0] : num_r[NUM_MAG_W-1:0]);
      div_den   = span_r[SPAN_W] ? span_neg[SPAN_W-1:0] : span_r[SPAN_W-1:0];
      div_iters = CNT_W'(N3);
    end
  end

  // pH seven for equal levels, else sign back on and clamp to the q8.8 range
  always_comb begin
    if (bad_r) begin
      ph_sat = ppsc_pkg::PH_SEVEN;
    end else if (!neg_r) begin
      ph_sat = (div_quo > DIV_W'(32767)) ? ppsc_pkg::PH_MAX : div_quo[PH_W-1:0];
    end else begin
      ph_sat = (div_quo > DIV_W'(32768)) ? ppsc_pkg::PH_MIN : (~div_quo[PH_W-1:0] + 1'b1);
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_IDLE) begin
      raw_rdata <= raw_ring[raw_slot];
    end
    if (state == S_RAW_UPD) begin
      raw_ring[raw_slot] <= sample;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_DIV1) begin
      avg_rdata <= avg_ring[avg_slot];
    end
    if (state == S_AVG_UPD) begin
      avg_ring[avg_slot] <= mean;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      raw_sum      <= '0;
      raw_fill     <= '0;
      raw_slot     <= '0;
      avg_sum      <= '0;
      avg_fill     <= '0;
      avg_slot     <= '0;
      result_valid <= 1'b0;
    end else begin
      // the output state reloads the result register on its own
      if (result_valid && result_ready && (state != S_OUT)) begin
        result_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (q_valid) begin
            sample <= q_data;
            state  <= S_RAW_UPD;
          end
        end
        S_RAW_UPD: begin
          raw_sum  <= raw_sum_next;
          raw_fill <= raw_fill_next;
          raw_slot <= raw_slot_next;
          state    <= S_DIV1;
        end
        S_DIV1: begin
          if (div_stat.done) begin
            mean  <= div_quo[MEAN_W-1:0];
            state <= S_AVG_UPD;
          end
        end
        S_AVG_UPD: begin
          avg_sum  <= avg_sum_next;
          avg_fill <= avg_fill_next;
          avg_slot <= avg_slot_next;
          state    <= S_DIV2;
        end
        S_DIV2: begin
          if (div_stat.done) begin
            avg2  <= div_quo[MEAN_W-1:0];
            state <= S_CAL;
          end
        end
        S_CAL: begin
          span_r <= signed'({1'b0, ph7_level, 4'b0000}) - signed'({1'b0, ph4_level, 4'b0000});
          diff_r <= signed'((CMP_W+1)'({ph7_level, 4'b0000})) - signed'((CMP_W+1)'(avg2));
          bad_r  <= (ph7_level == ph4_level);
          state  <= (ph7_level == ph4_level) ? S_OUT : S_NUM;
        end
        S_NUM: begin
          num_r <= (span_x <<< 11) - (span_x <<< 8) - (diff_x <<< 9) - (diff_x <<< 8);
          state <= S_START3;
        end
        S_START3: begin
          neg_r <= num_r[NUM_MAG_W] ^ span_r[SPAN_W];
          state <= S_DIV3;
        end
        S_DIV3: begin
          if (div_stat.done) begin
            state <= S_OUT;
          end
        end
        S_OUT: begin
          if (!result_valid || result_ready) begin
            result_valid    <= 1'b1;
            ph_value        <= ph_sat;
            calibration_bad <= bad_r;
            state           <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule
